FILE: sv/stall_watchdog_rearm_backoff_unit_defines.svh
// Assertion macros shared by the stall watchdog RTL.
// Depends on nothing; files that assert include it inside their module body.
`ifndef STALL_WATCHDOG_REARM_BACKOFF_UNIT_DEFINES_SVH
`define STALL_WATCHDOG_REARM_BACKOFF_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWRB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/swrb_pkg.sv
// Types and constants for the stall watchdog with rearm backoff.
// Depends on nothing; used by swrb_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swrb_pkg;

    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_ARM   = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NONE  = 2'd3
    } swrb_cmd_t;

    typedef enum logic [1:0] {
        REG_STALL        = 2'd0,
        REG_ACTIVE_RETRY = 2'd1,
        REG_QUIET_FIRST  = 2'd2,
        REG_QUIET_LATER  = 2'd3
    } swrb_reg_idx_t;

    localparam logic [15:0] STALL_INTERVAL_RST        = 16'd200;
    localparam logic [15:0] ACTIVE_RETRY_INTERVAL_RST = 16'd50;
    localparam logic [15:0] QUIET_RETRY_FIRST_RST     = 16'd100;
    localparam logic [15:0] QUIET_RETRY_LATER_RST     = 16'd500;

    localparam logic [7:0] ATTEMPT_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] stall_interval;
        logic [15:0] active_retry_interval;
        logic [15:0] quiet_retry_first;
        logic [15:0] quiet_retry_later;
    } swrb_cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_time;
        logic [31:0] progress_value;
        logic        underrun;
        logic        transmit_started;
        logic        receive_pending;
    } swrb_item_t;

endpackage

`default_nettype wire

FILE: sv/swrb_core.sv
// Watchdog state and rearm decision for one registered beat per cycle while enable is high.
// Depends on swrb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module swrb_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               enable,
    input  wire swrb_pkg::swrb_item_t item,
    input  wire swrb_pkg::swrb_cfg_t  cfg,
    output logic                    rearm_request
);
    import swrb_pkg::*;
    `include "stall_watchdog_rearm_backoff_unit_defines.svh"

    logic [31:0] seen_progress_reg, seen_progress_next;
    logic [31:0] progress_time_reg, progress_time_next;
    logic [31:0] rearm_time_reg, rearm_time_next;
    logic [7:0]  attempt_count_reg, attempt_count_next;
    logic        armed_flag_reg, armed_flag_next;

    logic [31:0] stall_elapsed;
    logic [31:0] retry_elapsed;
    logic [15:0] retry_wait;
    logic        progress_changed;
    logic        stall_met;
    logic        retry_met;
    logic        fire;

    assign progress_changed = item.progress_value != seen_progress_reg;
    assign stall_elapsed    = item.now_time - progress_time_reg;
    assign retry_elapsed    = item.now_time - rearm_time_reg;

    always_comb begin
        if (item.receive_pending) begin
            retry_wait = cfg.active_retry_interval;
        end else if (attempt_count_reg == 8'd1) begin
            retry_wait = cfg.quiet_retry_first;
        end else begin
            retry_wait = cfg.quiet_retry_later;
        end
    end

    assign stall_met = stall_elapsed >= {16'd0, cfg.stall_interval};
    assign retry_met = (attempt_count_reg == 8'd0) || (retry_elapsed >= {16'd0, retry_wait});
    assign fire = (item.command == CMD_CHECK) && !progress_changed && armed_flag_reg
                  && item.underrun && !item.transmit_started && stall_met && retry_met;

    assign rearm_request = fire;

    always_comb begin
        seen_progress_next = seen_progress_reg;
        progress_time_next = progress_time_reg;
        rearm_time_next    = rearm_time_reg;
        attempt_count_next = attempt_count_reg;
        armed_flag_next    = armed_flag_reg;
        case (item.command)
            CMD_RESET, CMD_ARM: begin
                seen_progress_next = item.progress_value;
                progress_time_next = item.now_time;
                rearm_time_next    = item.now_time;
                attempt_count_next = 8'd0;
                armed_flag_next    = item.command == CMD_ARM;
            end
            CMD_CHECK: begin
                if (progress_changed) begin
                    seen_progress_next = item.progress_value;
                    progress_time_next = item.now_time;
                    attempt_count_next = 8'd0;
                end else if (fire) begin
                    rearm_time_next = item.now_time;
                    if (attempt_count_reg != ATTEMPT_MAX) begin
                        attempt_count_next = attempt_count_reg + 8'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_progress_reg <= '0;
            progress_time_reg <= '0;
            rearm_time_reg    <= '0;
            attempt_count_reg <= '0;
            armed_flag_reg    <= 1'b0;
        end else if (enable) begin
            seen_progress_reg <= seen_progress_next;
            progress_time_reg <= progress_time_next;
            rearm_time_reg    <= rearm_time_next;
            attempt_count_reg <= attempt_count_next;
            armed_flag_reg    <= armed_flag_next;
        end
    end

    `SWRB_ASSERT_NOW(a_req_needs_armed_check, aclk, aresetn, rearm_request, (item.command == CMD_CHECK) && armed_flag_reg, "rearm requested outside an armed check")
    `SWRB_ASSERT_NEXT(a_arm_sets_state, aclk, aresetn, enable && (item.command == CMD_ARM), armed_flag_reg && (attempt_count_reg == 8'd0), "arm did not set armed and clear attempts")
    `SWRB_ASSERT_NEXT(a_attempt_counts, aclk, aresetn, enable && rearm_request && (attempt_count_reg != ATTEMPT_MAX), attempt_count_reg == $past(attempt_count_reg) + 8'd1, "attempt count did not advance on a rearm request")

endmodule

`default_nettype wire

FILE: sv/stall_watchdog_rearm_backoff_unit.sv
// Top level of the receive-stall watchdog with rearm backoff.
// Depends on swrb_pkg, swrb_core and the assertion macro header.
//
// Usage:
// Input beats (s_valid/s_ready) carry a command, a millisecond timestamp, a
// progress count and three status flags. Every input beat yields exactly one
// output beat (m_valid/m_ready) carrying m_rearm_request.
// An accepted beat lands in an input register; when it advances, the watchdog
// state is updated and the result is written to the output register at the
// same edge.
// Throughput is one beat per cycle while the receiver keeps up, set by the state
// update in swrb_core: the input stage advances whenever the output register is
// empty or being taken in the same cycle.
// When the receiver stalls, the result holds in the output register and one
// more beat is held in the input register; s_ready then drops.
// Reset clears the watchdog state, empties both stages and loads the interval
// registers with 200, 50, 100 and 500 ms. The user must write the interval
// registers through the APB port while no beat is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module stall_watchdog_rearm_backoff_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [31:0] s_now_time,
    input  wire logic [31:0] s_progress_value,
    input  wire logic        s_underrun,
    input  wire logic        s_transmit_started,
    input  wire logic        s_receive_pending,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_rearm_request,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import swrb_pkg::*;
    `include "stall_watchdog_rearm_backoff_unit_defines.svh"

    swrb_cfg_t     cfg_reg;
    swrb_item_t    in_item_reg;
    logic          in_valid_reg;
    logic          m_valid_reg;
    logic          m_rearm_request_reg;
    logic          advance;
    logic          core_request;
    logic          cfg_write;
    swrb_reg_idx_t cfg_idx;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_rearm_request = m_rearm_request_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = swrb_reg_idx_t'(paddr[3:2]);

    always_comb begin
        case (cfg_idx)
            REG_STALL:        prdata = {16'd0, cfg_reg.stall_interval};
            REG_ACTIVE_RETRY: prdata = {16'd0, cfg_reg.active_retry_interval};
            REG_QUIET_FIRST:  prdata = {16'd0, cfg_reg.quiet_retry_first};
            REG_QUIET_LATER:  prdata = {16'd0, cfg_reg.quiet_retry_later};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stall_interval        <= STALL_INTERVAL_RST;
            cfg_reg.active_retry_interval <= ACTIVE_RETRY_INTERVAL_RST;
            cfg_reg.quiet_retry_first     <= QUIET_RETRY_FIRST_RST;
            cfg_reg.quiet_retry_later     <= QUIET_RETRY_LATER_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_STALL:        cfg_reg.stall_interval        <= pwdata[15:0];
                REG_ACTIVE_RETRY: cfg_reg.active_retry_interval <= pwdata[15:0];
                REG_QUIET_FIRST:  cfg_reg.quiet_retry_first     <= pwdata[15:0];
                REG_QUIET_LATER:  cfg_reg.quiet_retry_later     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.command          <= s_command;
            in_item_reg.now_time         <= s_now_time;
            in_item_reg.progress_value   <= s_progress_value;
            in_item_reg.underrun         <= s_underrun;
            in_item_reg.transmit_started <= s_transmit_started;
            in_item_reg.receive_pending  <= s_receive_pending;
        end
        if (advance) begin
            m_rearm_request_reg <= core_request;
        end
    end

    swrb_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enable        (advance),
        .item          (in_item_reg),
        .cfg           (cfg_reg),
        .rearm_request (core_request)
    );

    `SWRB_ASSERT_NOW(a_empty_stage_ready, aclk, aresetn, !in_valid_reg, s_ready, "input stage empty but not ready")
    `SWRB_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, m_valid_reg, "advanced beat did not reach the output register")
    `SWRB_ASSERT_NEXT(a_blocked_stage_holds, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg), "blocked input stage lost its beat")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for stall_watchdog_rearm_backoff_unit: a clocked driver and monitor
// with random idling, an in-bench watchdog predictor, and APB interval writes between phases.
// Depends on swrb_pkg and the unit under test.
`timescale 1ns / 1ps

module tb;
    import swrb_pkg::*;

    logic        aclk;
    logic        aresetn            = 1'b0;
    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command          = '0;
    logic [31:0] s_now_time         = '0;
    logic [31:0] s_progress_value   = '0;
    logic        s_underrun         = 1'b0;
    logic        s_transmit_started = 1'b0;
    logic        s_receive_pending  = 1'b0;
    logic        m_valid;
    logic        m_ready            = 1'b0;
    logic        m_rearm_request;
    logic        psel               = 1'b0;
    logic        penable            = 1'b0;
    logic        pwrite             = 1'b0;
    logic [3:0]  paddr              = '0;
    logic [31:0] pwdata             = '0;
    logic [31:0] prdata;
    logic        pready;

    stall_watchdog_rearm_backoff_unit u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_now_time        (s_now_time),
        .s_progress_value  (s_progress_value),
        .s_underrun        (s_underrun),
        .s_transmit_started(s_transmit_started),
        .s_receive_pending (s_receive_pending),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_rearm_request   (m_rearm_request),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    swrb_item_t  pending_beat_q[$];
    bit          rearm_expected_q[$];
    swrb_item_t  beat_out;
    bit          want_rearm;
    bit          idle_on = 1'b1;
    int          src_gap;
    int          sink_gap;
    int          n_sent;
    int          n_results;
    int          n_rearms;
    int          n_writes;
    int          n_errors;

    logic [15:0] cfg_stall;
    logic [15:0] cfg_active;
    logic [15:0] cfg_quiet_first;
    logic [15:0] cfg_quiet_later;

    logic [31:0] wd_seen;
    logic [31:0] wd_progress_t;
    logic [31:0] wd_rearm_t;
    logic [7:0]  wd_attempts;
    logic        wd_armed;

    logic [31:0] clock_ms;
    logic [31:0] count_now;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit watchdog_predict(input swrb_item_t it);
        logic [31:0] hold_ms;
        bit          req;
        req = 1'b0;
        case (swrb_cmd_t'(it.command))
            CMD_RESET, CMD_ARM: begin
                wd_seen       = it.progress_value;
                wd_progress_t = it.now_time;
                wd_rearm_t    = it.now_time;
                wd_attempts   = '0;
                wd_armed      = (swrb_cmd_t'(it.command) == CMD_ARM);
            end
            CMD_CHECK: begin
                if (it.progress_value != wd_seen) begin
                    wd_seen       = it.progress_value;
                    wd_progress_t = it.now_time;
                    wd_attempts   = '0;
                end else if (wd_armed && it.underrun && !it.transmit_started
                             && (it.now_time - wd_progress_t) >= {16'd0, cfg_stall}) begin
                    if (wd_attempts == '0) begin
                        req = 1'b1;
                    end else begin
                        if (it.receive_pending)
                            hold_ms = {16'd0, cfg_active};
                        else if (wd_attempts == 8'd1)
                            hold_ms = {16'd0, cfg_quiet_first};
                        else
                            hold_ms = {16'd0, cfg_quiet_later};
                        req = ((it.now_time - wd_rearm_t) >= hold_ms);
                    end
                    if (req) begin
                        wd_rearm_t = it.now_time;
                        if (wd_attempts != ATTEMPT_MAX)
                            wd_attempts = wd_attempts + 8'd1;
                    end
                end
            end
            default: req = 1'b0;
        endcase
        return req;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch at result %0d: %s", $time, n_results, what);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                rearm_expected_q.push_back(watchdog_predict(beat_out));
            end
            if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                src_gap <= $urandom_range(0, 9);
                s_valid <= 1'b0;
            end else if (pending_beat_q.size() != 0) begin
                beat_out = pending_beat_q.pop_front();
                s_command          <= beat_out.command;
                s_now_time         <= beat_out.now_time;
                s_progress_value   <= beat_out.progress_value;
                s_underrun         <= beat_out.underrun;
                s_transmit_started <= beat_out.transmit_started;
                s_receive_pending  <= beat_out.receive_pending;
                s_valid            <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (rearm_expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want_rearm = rearm_expected_q.pop_front();
                    if (m_rearm_request !== want_rearm)
                        report_mismatch($sformatf("rearm_request %b, expected %b",
                                                  m_rearm_request, want_rearm));
                    if (want_rearm)
                        n_rearms++;
                end
                n_results++;
            end
            if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_ready  <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 9);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_beat(input swrb_cmd_t cmd, input logic [31:0] t,
                              input logic [31:0] p, input logic [2:0] flags);
        swrb_item_t it;
        it.command          = cmd;
        it.now_time         = t;
        it.progress_value   = p;
        it.underrun         = flags[2];
        it.transmit_started = flags[1];
        it.receive_pending  = flags[0];
        pending_beat_q.push_back(it);
        n_sent++;
    endtask

    task automatic write_interval(input swrb_reg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_STALL:        cfg_stall       = val;
            REG_ACTIVE_RETRY: cfg_active      = val;
            REG_QUIET_FIRST:  cfg_quiet_first = val;
            REG_QUIET_LATER:  cfg_quiet_later = val;
            default: ;
        endcase
        n_writes++;
    endtask

    task automatic program_intervals(input logic [15:0] stall, input logic [15:0] active,
                                     input logic [15:0] first, input logic [15:0] later);
        write_interval(REG_STALL, stall);
        write_interval(REG_ACTIVE_RETRY, active);
        write_interval(REG_QUIET_FIRST, first);
        write_interval(REG_QUIET_LATER, later);
    endtask

    task automatic wait_drained();
        while (n_results < n_sent)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_interval();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(1, 400));
    endfunction

    // Arm (or disarm), then a run of checks with a slowly moving clock and mostly
    // stalled progress; a tenth of the beats are random noise.
    task automatic queue_session(input int n_checks, input int step_max);
        logic [31:0] jump;
        if ($urandom_range(0, 1) == 0)
            count_now = $urandom;
        queue_beat(($urandom_range(0, 5) == 0) ? CMD_RESET : CMD_ARM, clock_ms, count_now,
                   3'($urandom_range(0, 7)));
        for (int i = 0; i < n_checks; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_beat(swrb_cmd_t'($urandom_range(0, 3)), $urandom,
                           ($urandom_range(0, 1) == 0) ? count_now : $urandom,
                           3'($urandom_range(0, 7)));
            end else begin
                if ($urandom_range(0, 19) == 0)
                    jump = $urandom_range(0, 70000);
                else
                    jump = $urandom_range(0, step_max);
                clock_ms = clock_ms + jump;
                if ($urandom_range(0, 11) == 0)
                    count_now = count_now + $urandom_range(1, 3);
                queue_beat(CMD_CHECK, clock_ms, count_now,
                           {$urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0,
                            1'($urandom_range(0, 1))});
            end
        end
    endtask

    localparam logic [31:0] T0 = 32'hFFFF_FF80;

    initial begin
        int base;
        cfg_stall       = STALL_INTERVAL_RST;
        cfg_active      = ACTIVE_RETRY_INTERVAL_RST;
        cfg_quiet_first = QUIET_RETRY_FIRST_RST;
        cfg_quiet_later = QUIET_RETRY_LATER_RST;
        wd_seen         = '0;
        wd_progress_t   = '0;
        wd_rearm_t      = '0;
        wd_attempts     = '0;
        wd_armed        = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats under the reset intervals; the timer wraps past zero.
        queue_beat(CMD_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
        queue_beat(CMD_NONE,  $urandom, $urandom, 3'b111);
        queue_beat(CMD_CHECK, 32'd100, 32'hFFFF_FFFF, 3'b100);
        queue_beat(CMD_ARM,   T0, 32'd0, 3'b000);
        queue_beat(CMD_CHECK, T0 + 199, 32'd0, 3'b100);
        queue_beat(CMD_CHECK, T0 + 200, 32'd0, 3'b100);
        queue_beat(CMD_CHECK, T0 + 300, 32'd0, 3'b110);
        queue_beat(CMD_CHECK, T0 + 300, 32'd0, 3'b000);
        queue_beat(CMD_CHECK, T0 + 230, 32'd0, 3'b101);
        queue_beat(CMD_CHECK, T0 + 250, 32'd0, 3'b101);
        queue_beat(CMD_CHECK, T0 + 350, 32'd0, 3'b100);
        queue_beat(CMD_CHECK, T0 + 750, 32'd0, 3'b100);
        queue_beat(CMD_CHECK, T0 + 760, 32'd1, 3'b100);
        queue_beat(CMD_CHECK, T0 + 960, 32'd1, 3'b100);
        queue_beat(CMD_CHECK, T0 + 1060, 32'd1, 3'b100);
        queue_beat(CMD_CHECK, T0 + 1100, 32'd1, 3'b101);
        queue_beat(CMD_NONE,  T0 + 1105, 32'd7, 3'b101);
        queue_beat(CMD_CHECK, T0 + 1110, 32'd1, 3'b101);
        queue_beat(CMD_RESET, T0 + 1200, 32'd1, 3'b100);
        queue_beat(CMD_CHECK, T0 + 5000, 32'd1, 3'b100);
        queue_beat(CMD_CHECK, 32'd0, 32'd0, 3'b000);
        wait_drained();

        // Zero intervals: every starved check requests, so the attempt count saturates.
        program_intervals(16'd0, 16'd0, 16'd0, 16'd0);
        clock_ms  = 32'hFFFF_FF00;
        count_now = $urandom;
        queue_beat(CMD_ARM, clock_ms, count_now, 3'b000);
        for (int i = 0; i < 300; i++) begin
            clock_ms = clock_ms + $urandom_range(0, 3);
            queue_beat(CMD_CHECK, clock_ms, count_now, {2'b10, 1'($urandom_range(0, 1))});
        end
        wait_drained();

        // Maximum retry spacing on a saturated count: only long gaps request.
        program_intervals(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 40; i++) begin
            clock_ms = clock_ms + (($urandom_range(0, 7) == 0) ? $urandom_range(60000, 70000)
                                                                 : $urandom_range(0, 1000));
            queue_beat(CMD_CHECK, clock_ms, count_now, {2'b10, 1'($urandom_range(0, 1))});
        end
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            program_intervals(pick_interval(), pick_interval(), pick_interval(),
                              pick_interval());
            idle_on  = (ph != 5) && ($urandom_range(0, 3) != 0);
            clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_F000 : $urandom;
            base     = n_sent;
            while (n_sent - base < 100)
                queue_session($urandom_range(5, 40), $urandom_range(1, 150));
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (rearm_expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", rearm_expected_q.size()));
        $display("Run covered %0d beats with %0d rearm requests over %0d interval writes.",
                 n_results, n_rearms, n_writes);
        if (n_errors == 0)
            $display("[stall_watchdog_rearm_backoff_unit] OK");
        else
            $display("[stall_watchdog_rearm_backoff_unit] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d of %0d results received.", n_results, n_sent);
        $display("[stall_watchdog_rearm_backoff_unit] ERROR");
        $finish;
    end

endmodule
